// ===== hw/rtl/sgi_pkg.sv =====
`default_nettype none
package sgi_pkg;

  localparam int unsigned NMaxW = 24;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic [19:0]       intervals;
  } req_t;

  typedef struct packed {
    logic signed [39:0] integral;
    logic               status;
  } resp_t;

  typedef struct packed {
    logic               err;
    logic               three8;
    logic               neg;
    logic signed [31:0] lo;
    logic [32:0]        dm;
    logic [NMaxW-1:0]   n;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV1,
    BK_RUN,
    BK_DRAIN,
    BK_MUL,
    BK_DIV2,
    BK_OUT
  } bk_state_e;

  function automatic logic mod3_zero(input logic [NMaxW-1:0] n);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = '0;
    for (int k = 0; k < NMaxW / 2; k++) begin
      s1 = s1 + 6'(n[2*k +: 2]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
    return (s2 == 4'd0) || (s2 == 4'd3) || (s2 == 4'd6) || (s2 == 4'd9);
  endfunction

  function automatic logic [31:0] exp_neg_unit(input logic [63:0] u);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = 64'sd2147483648;
    term = 64'd2147483648;
    for (int j = 1; j <= 24; j++) begin
      term = ((term * u + 64'd1073741824) >> 31) / 64'(j);
      if ((j % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd2147483648) begin
      sum = 64'sd2147483648;
    end
    return sum[31:0];
  endfunction

  function automatic logic [31:0] exp_entry(input logic [63:0] u, input logic [5:0] q);
    logic [63:0] v;
    logic [63:0] e1;
    v  = 64'(exp_neg_unit(u));
    e1 = 64'(exp_neg_unit(64'd2147483648));
    for (int j = 0; j < 32; j++) begin
      if (6'(j) < q) begin
        v = (v * e1 + 64'd1073741824) >> 31;
      end
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/simpson_gaussian_integrator_unit.sv =====
`default_nettype none
// A count the rule rejects goes from the back end's idle state straight to the output;
//   otherwise the job runs two serial divides, n+1 samples and a 33-step
//   multiply.
// Throughput: one transaction at a time in the back end; the sample loop takes one point a cycle.
// A two-entry queue lets the front end take up to three further transactions meanwhile.
// Reset clears all control state; the exp table is constant logic and needs no fill.
module simpson_gaussian_integrator_unit #(
  parameter int MAX_INTERVALS_BITS = 20,
  parameter int EXP_TABLE_ENTRIES  = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire sgi_pkg::req_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output sgi_pkg::resp_t      out_data_o
);
  import sgi_pkg::*;

  logic fq_valid, fq_ready, bq_valid, bq_ready;
  job_t fq_job, bq_job;

  sgi_front #(.MAX_INTERVALS_BITS(MAX_INTERVALS_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .job_valid_o(fq_valid),
    .job_ready_i(fq_ready),
    .job_o      (fq_job)
  );

  sgi_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_job),
    .pop_valid_o (bq_valid),
    .pop_ready_i (bq_ready),
    .pop_data_o  (bq_job)
  );

  sgi_back #(
    .MAX_INTERVALS_BITS(MAX_INTERVALS_BITS),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(bq_valid),
    .job_ready_o(bq_ready),
    .job_i      (bq_job),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sgi_front.sv =====
`default_nettype none
module sgi_front #(
  parameter int MAX_INTERVALS_BITS = 20
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sgi_pkg::req_t in_data_i,
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output sgi_pkg::job_t      job_o
);
  import sgi_pkg::*;

  localparam logic [NMaxW-1:0] NMask = NMaxW'((25'd1 << MAX_INTERVALS_BITS) - 25'd1);

  logic              fv_q;
  job_t              job_q, job_d;
  logic [NMaxW-1:0]  n_w;
  logic signed [32:0] d_w;

  assign in_ready_o  = !fv_q || job_ready_i;
  assign job_valid_o = fv_q;
  assign job_o       = job_q;

  always_comb begin
    n_w = NMaxW'(in_data_i.intervals) & NMask;
    d_w = 33'(in_data_i.upper_bound) - 33'(in_data_i.lower_bound);
    job_d.three8 = in_data_i.req_type;
    job_d.err    = (n_w == '0) || (in_data_i.req_type ? !mod3_zero(n_w) : n_w[0]);
    job_d.neg    = d_w[32];
    job_d.lo     = in_data_i.lower_bound;
    job_d.dm     = d_w[32] ? 33'(-d_w) : 33'(d_w);
    job_d.n      = n_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      fv_q <= 1'b1;
    end else if (job_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      job_q <= job_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sgi_fifo.sv =====
`default_nettype none
module sgi_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire sgi_pkg::job_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output sgi_pkg::job_t      pop_data_o
);
  import sgi_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push_w, pop_w;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rp_q];
  assign push_w       = push_valid_i && push_ready_o;
  assign pop_w        = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_w) begin
        wp_q <= !wp_q;
      end
      if (pop_w) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_w) - 2'(pop_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sgi_div.sv =====
`default_nettype none
module sgi_div #(
  parameter int NW = 89,
  parameter int DW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o,
  output logic [DW-1:0]      rem_o
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [DW:0]   sh_w;
  logic          ge_w;

  assign sh_w   = {rem_q, quo_q[NW-1]};
  assign ge_w   = (sh_w >= {1'b0, dvs_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NW);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge_w ? DW'(sh_w - {1'b0, dvs_q}) : sh_w[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge_w};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sgi_back.sv =====
`default_nettype none
module sgi_back #(
  parameter int MAX_INTERVALS_BITS = 20,
  parameter int EXP_TABLE_ENTRIES  = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire sgi_pkg::job_t job_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sgi_pkg::resp_t     out_data_o
);
  import sgi_pkg::*;

  localparam int MB = MAX_INTERVALS_BITS;
  localparam int SW = MB + 34;
  localparam int MW = SW + 2;
  localparam int PW = MW + 33;
  localparam int DW = MB + 3;
  localparam int IW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int QW = 33;
  localparam int RW = PW - 27;

  logic [31:0] rom_w [EXP_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++) begin : g_rom
    localparam longint unsigned QI = (64'd32 * k) / EXP_TABLE_ENTRIES;
    localparam longint unsigned UI = (((64'd32 * k) % EXP_TABLE_ENTRIES) << 31)
                                     / EXP_TABLE_ENTRIES;
    assign rom_w[k] = exp_entry(UI, QI[5:0]);
  end

  bk_state_e state_q, state_d;
  job_t      job_q;
  logic [QW-1:0] q0_q, gq_q;
  logic [MB-1:0] r0_q, gr_q, i_q, n_w;
  logic [1:0]    ph_q;

  logic [5:0]    vld_q;
  logic [31:0]   mag1_q;
  logic [2:0]    w1_q, w2_q, w3_q, w4_q, w5_q;
  logic [63:0]   sq2_q;
  logic [IW-1:0] idx3_q;
  logic [30:0]   fr3_q, fr4_q;
  logic          z3_q, z4_q, z5_q, dec4_q, dec5_q;
  logic [31:0]   y0_4_q, y0_5_q, diff4_q;
  logic [62:0]   prod5_q;
  logic [34:0]   wf6_q;
  logic [SW-1:0] acc_q;

  logic [PW-1:0] mcand_q, prod_q;
  logic [32:0]   mplier_q;
  logic [5:0]    mcnt_q;

  logic  out_valid_q;
  resp_t out_q, out_d;

  logic          pop_w, div_start_w, issue_w, out_load_w;
  logic [PW-1:0] div_dvd_w, div_quo_w;
  logic [DW-1:0] div_dvs_w, div_rem_w;
  logic          div_done_w;

  logic [2:0]         wt_w;
  logic signed [33:0] x_w;
  logic [31:0]        mag_w;
  logic [MB:0]        rs_w;
  logic               wrap_w;
  logic [35:0]        t_w;
  logic [48:0]        pos_w;
  logic [15:0]        idxf_w;
  logic [31:0]        y0_w, y1_w, f_w;
  logic [RW-1:0]      res_w;
  logic               big_w;

  assign n_w         = job_q.n[MB-1:0];
  assign job_ready_o = pop_w;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  sgi_div #(.NW(PW), .DW(DW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_w),
    .dividend_i(div_dvd_w),
    .divisor_i (div_dvs_w),
    .done_o    (div_done_w),
    .quo_o     (div_quo_w),
    .rem_o     (div_rem_w)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (job_valid_i) state_d = job_i.err ? BK_OUT : BK_DIV1;
      BK_DIV1:  if (div_done_w) state_d = BK_RUN;
      BK_RUN:   if (i_q == n_w) state_d = BK_DRAIN;
      BK_DRAIN: if (vld_q == '0) state_d = BK_MUL;
      BK_MUL:   if (mcnt_q == '0) state_d = BK_DIV2;
      BK_DIV2:  if (div_done_w) state_d = BK_OUT;
      BK_OUT:   if (!out_valid_q || out_ready_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_w       = (state_q == BK_IDLE) && job_valid_i;
    div_start_w = (pop_w && !job_i.err) || ((state_q == BK_MUL) && (mcnt_q == '0));
    issue_w     = (state_q == BK_RUN);
    out_load_w  = (state_q == BK_OUT) && (!out_valid_q || out_ready_i);
    if (state_q == BK_IDLE) begin
      div_dvd_w = PW'(job_i.dm);
      div_dvs_w = DW'(job_i.n[MB-1:0]);
    end else begin
      div_dvd_w = prod_q;
      div_dvs_w = job_q.three8 ? {n_w, 3'b000} : DW'(n_w) + (DW'(n_w) << 1);
    end
  end

  always_comb begin
    if ((i_q == '0) || (i_q == n_w)) begin
      wt_w = 3'd1;
    end else if (job_q.three8) begin
      wt_w = (ph_q == 2'd0) ? 3'd2 : 3'd3;
    end else begin
      wt_w = i_q[0] ? 3'd4 : 3'd2;
    end
    x_w    = 34'(job_q.lo) + (job_q.neg ? -$signed({1'b0, gq_q}) : $signed({1'b0, gq_q}));
    mag_w  = x_w[33] ? 32'(-x_w) : x_w[31:0];
    rs_w   = {1'b0, gr_q} + {1'b0, r0_q};
    wrap_w = (rs_w >= {1'b0, n_w});
    t_w    = sq2_q[63:28];
    pos_w  = 49'(t_w) * 49'(EXP_TABLE_ENTRIES);
    idxf_w = pos_w[48:33];
    y0_w   = rom_w[idx3_q];
    y1_w   = rom_w[idx3_q + IW'(1)];
    if (z5_q) begin
      f_w = '0;
    end else if (dec5_q) begin
      f_w = y0_5_q - prod5_q[62:31];
    end else begin
      f_w = y0_5_q + prod5_q[62:31];
    end
  end

  always_comb begin
    res_w = prod_q[PW-1:27];
    big_w = |res_w[RW-1:40];
    out_d.status = job_q.err;
    if (job_q.err) begin
      out_d.integral = '0;
    end else if (job_q.neg) begin
      if (big_w || (res_w[39] && |res_w[38:0])) begin
        out_d.integral = 40'sh80_0000_0000;
      end else begin
        out_d.integral = -$signed(res_w[39:0]);
      end
    end else begin
      if (big_w || res_w[39]) begin
        out_d.integral = 40'sh7F_FFFF_FFFF;
      end else begin
        out_d.integral = $signed(res_w[39:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= {vld_q[4:0], issue_w};
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_w) begin
      job_q <= job_i;
    end
    if ((state_q == BK_DIV1) && div_done_w) begin
      q0_q  <= div_quo_w[QW-1:0];
      r0_q  <= div_rem_w[MB-1:0];
      i_q   <= '0;
      gq_q  <= '0;
      gr_q  <= '0;
      ph_q  <= 2'd0;
      acc_q <= '0;
    end
    if (issue_w) begin
      i_q  <= i_q + MB'(1);
      gr_q <= wrap_w ? MB'(rs_w - {1'b0, n_w}) : rs_w[MB-1:0];
      gq_q <= gq_q + q0_q + QW'(wrap_w);
      ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
    end
    mag1_q  <= mag_w;
    w1_q    <= wt_w;
    sq2_q   <= mag1_q * mag1_q;
    w2_q    <= w1_q;
    z3_q    <= (idxf_w >= 16'(EXP_TABLE_ENTRIES));
    idx3_q  <= (idxf_w >= 16'(EXP_TABLE_ENTRIES)) ? '0 : idxf_w[IW-1:0];
    fr3_q   <= pos_w[32:2];
    w3_q    <= w2_q;
    y0_4_q  <= y0_w;
    dec4_q  <= (y0_w >= y1_w);
    diff4_q <= (y0_w >= y1_w) ? y0_w - y1_w : y1_w - y0_w;
    fr4_q   <= fr3_q;
    z4_q    <= z3_q;
    w4_q    <= w3_q;
    prod5_q <= 63'(diff4_q) * 63'(fr4_q);
    y0_5_q  <= y0_4_q;
    dec5_q  <= dec4_q;
    z5_q    <= z4_q;
    w5_q    <= w4_q;
    wf6_q   <= 35'(f_w) * 35'(w5_q);
    if (vld_q[5]) begin
      acc_q <= acc_q + SW'(wf6_q);
    end
    if ((state_q == BK_DRAIN) && (vld_q == '0)) begin
      mcand_q  <= job_q.three8 ? PW'(acc_q) + (PW'(acc_q) << 1) : PW'(acc_q);
      mplier_q <= job_q.dm;
      prod_q   <= '0;
      mcnt_q   <= 6'd33;
    end
    if ((state_q == BK_MUL) && (mcnt_q != '0)) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      mcnt_q   <= mcnt_q - 6'd1;
    end
    if ((state_q == BK_DIV2) && div_done_w) begin
      prod_q <= div_quo_w;
    end
    if (out_load_w) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== dv/integral_checker.sv =====
`timescale 1ns / 1ps
module integral_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_ready_i,
  input  wire sgi_pkg::req_t  in_data_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_ready_i,
  input  wire sgi_pkg::resp_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import sgi_pkg::*;

  localparam int unsigned TableSize = 256;
  localparam logic [63:0] QOne  = 64'd2147483648;
  localparam logic [63:0] QHalf = 64'd1073741824;
  localparam logic [63:0] Frac33 = 64'h1_FFFF_FFFF;
  localparam logic [63:0] SatHi = 64'd549755813887;
  localparam logic [63:0] SatLo = 64'd549755813888;

  logic [63:0] gauss_rom [TableSize+1];
  resp_t       integral_fifo[$];
  int          fails;

  assign fail_count_o = fails;

  function automatic logic [63:0] taylor_exp_q31(input logic [63:0] u);
    logic signed [63:0] acc;
    logic [63:0]        term;
    acc  = QOne;
    term = QOne;
    for (int j = 1; j <= 24; j++) begin
      term = ((term * u + QHalf) >> 31) / 64'(j);
      if (j % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > $signed(QOne)) acc = QOne;
    return acc;
  endfunction

  function automatic logic [63:0] gauss_q31(input longint x);
    logic [63:0] mag, t, pos, idx, fr, y0, y1;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    t   = (mag * mag) >> 28;
    pos = t * TableSize;
    idx = pos >> 33;
    if (idx >= TableSize) return 0;
    fr = (pos & Frac33) >> 2;
    y0 = gauss_rom[idx];
    y1 = gauss_rom[idx+1];
    if (y0 >= y1) return y0 - (((y0 - y1) * fr) >> 31);
    return y0 + (((y1 - y0) * fr) >> 31);
  endfunction

  function automatic resp_t simpson_integral(input req_t r);
    resp_t       o;
    logic        three8, neg;
    logic [63:0] n, s, wt, num, den, dm, m, q, rm, res;
    longint      a, b, d, x;
    three8 = r.req_type;
    n = 64'(r.intervals);
    o = '0;
    if (n == 0 || (!three8 && n[0]) || (three8 && (n % 3) != 0)) begin
      o.status = 1'b1;
      return o;
    end
    a = longint'(r.lower_bound);
    b = longint'(r.upper_bound);
    d = b - a;
    s = 0;
    for (longint i = 0; i <= longint'(n); i++) begin
      x = a + (i * d) / longint'(n);
      if (i == 0 || i == longint'(n)) wt = 1;
      else if (three8) wt = (i % 3 == 0) ? 2 : 3;
      else wt = i[0] ? 4 : 2;
      s = s + wt * gauss_q31(x);
    end
    num = three8 ? 3 : 1;
    den = three8 ? 8 * n : 3 * n;
    neg = d < 0;
    dm  = neg ? 64'(-d) : 64'(d);
    m   = s * num;
    q   = m / den;
    rm  = m % den;
    res = (dm * q + (dm * rm) / den) >> 27;
    if (neg) begin
      if (res > SatLo) res = SatLo;
      o.integral = 40'(64'd0 - res);
    end else begin
      if (res > SatHi) res = SatHi;
      o.integral = 40'(res);
    end
    return o;
  endfunction

  initial begin
    logic [63:0] e1, v, pt;
    fails     = 0;
    pending_o = 0;
    e1 = taylor_exp_q31(QOne);
    for (int k = 0; k <= TableSize; k++) begin
      pt = 64'(32 * k);
      v  = taylor_exp_q31(((pt % TableSize) << 31) / TableSize);
      for (int j = 0; j < int'(pt / TableSize); j++) v = (v * e1 + QHalf) >> 31;
      gauss_rom[k] = v;
    end
  end

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) integral_fifo.push_back(simpson_integral(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (integral_fifo.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: integral %0d status %0d",
                                    out_data_i.integral, out_data_i.status);
        end else begin
          want = integral_fifo.pop_front();
          if (want.integral !== out_data_i.integral || want.status !== out_data_i.status) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected integral %0d status %0d, got integral %0d status %0d",
                       want.integral, want.status, out_data_i.integral, out_data_i.status);
          end
        end
      end
      pending_o = integral_fifo.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sgi_pkg::*;

  localparam longint unsigned CycleLimit = 4000000;
  localparam int Settle = 300;
  localparam logic signed [31:0] QUnit = 32'sd268435456;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid;
  logic  in_ready;
  req_t  in_data;
  logic  out_valid;
  logic  out_ready;
  resp_t out_data;
  int    fail_count;
  int    pending;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_cycles;
  int    sent;
  longint unsigned cycles;

  always #1 clk_i = ~clk_i;

  simpson_gaussian_integrator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  integral_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int stretch;
    stretch = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        stretch = hold_cycles;
        hold_cycles = 0;
      end
      if (stretch > 0) begin
        stretch--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic offer_request(input req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic offer_fields(input logic rule, input logic [31:0] lo, input logic [31:0] hi,
                              input logic [19:0] n);
    req_t r;
    r.req_type    = rule;
    r.lower_bound = lo;
    r.upper_bound = hi;
    r.intervals   = n;
    offer_request(r);
  endtask

  task automatic drain_and_pause();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (Settle) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_bound();
    if ($urandom_range(99) < 30) return $urandom;
    return {($urandom_range(1) != 0) ? 3'b111 : 3'b000, 29'($urandom)};
  endfunction

  task automatic offer_random();
    logic        rule;
    logic [19:0] n;
    rule = 1'($urandom_range(1));
    if ($urandom_range(99) < 12) begin
      n = 20'($urandom);
      if (!rule && !n[0]) n = n ^ 20'd1;
      if (rule && n % 3 == 0) n = n + 20'd1;
    end else if (!rule) begin
      n = 20'(2 * $urandom_range(1, 32));
    end else begin
      n = 20'(3 * $urandom_range(1, 20));
    end
    offer_fields(rule, random_bound(), random_bound(), n);
  endtask

  initial begin
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    sent           = 0;
    cycles         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_fields(1'b0, 32'sd0, QUnit, 20'd0);
    offer_fields(1'b1, 32'sd0, QUnit, 20'd0);
    offer_fields(1'b0, 32'sd0, QUnit, 20'd1);
    offer_fields(1'b0, 32'sd0, QUnit, 20'd2);
    offer_fields(1'b1, 32'sd0, QUnit, 20'd3);
    offer_fields(1'b0, 32'sd0, QUnit, 20'd3);
    offer_fields(1'b1, 32'sd0, QUnit, 20'd2);
    offer_fields(1'b0, QUnit, QUnit, 20'd4);
    offer_fields(1'b1, QUnit, -QUnit, 20'd6);
    offer_fields(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 20'd2);
    offer_fields(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 20'd6);
    offer_fields(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 20'd12);
    offer_fields(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 20'd12);
    offer_fields(1'b0, -QUnit, QUnit, 20'hFFFFF);
    offer_fields(1'b1, -QUnit, QUnit, 20'hFFFFE);
    offer_fields(1'b0, 32'sd0, QUnit, 20'd6000);
    offer_fields(1'b1, 32'hFFFF_FFFF, 32'sd1, 20'd9);
    drain_and_pause();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 78 : (ph == 3) ? 34 : 0;
      repeat (20) offer_random();
      drain_and_pause();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 2000;
    repeat (8) offer_fields(1'b0, 32'sd0, QUnit, 20'd2);
    drain_and_pause();

    $display("sent %0d requests: both rules, rejected counts, reversed and extreme bounds,",
             sent);
    $display("sender gaps, receiver stalls and a long output hold-off");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== simpson_gaussian_integrator_unit.f =====
hw/rtl/sgi_pkg.sv
hw/rtl/sgi_front.sv
hw/rtl/sgi_fifo.sv
hw/rtl/sgi_div.sv
hw/rtl/sgi_back.sv
hw/rtl/simpson_gaussian_integrator_unit.sv
dv/integral_checker.sv
dv/testbench.sv
